[hdl/dfrc_pkg.sv]
// shared types, codes and constants for the frame receiver and command reassembly
// no dependencies

package dfrc_pkg;

  localparam int CmdBufferDepth = 32;
  localparam int TableDepth     = 256;
  localparam int QueueDepth     = 4;

  localparam logic [7:0] DleByte   = 8'h10;
  localparam logic [7:0] EtxByte   = 8'h03;
  localparam logic [7:0] IdGpsPos  = 8'h10;
  localparam logic [7:0] IdSciFrag = 8'h14;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ID,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    MSG_GPS_POS,
    MSG_GPS_TIME,
    MSG_ALT,
    MSG_REQ,
    MSG_SCI
  } msg_t;

  typedef enum logic [1:0] {
    OP_TABLE,
    OP_REQ,
    OP_NO_ETX,
    OP_FRAG
  } op_code_t;

  typedef struct packed {
    op_code_t    code;
    logic [7:0]  a;
    logic [7:0]  b;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    KIND_REQ      = 3'd0,
    KIND_KNOWN    = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_NO_ETX   = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_EMIT_RD,
    BK_EMIT_WR
  } bk_state_t;

  // position of the final (etx) byte within each message body
  function automatic logic [3:0] body_last(msg_t k);
    logic [3:0] r;
    r = 4'd0;
    case (k)
      MSG_GPS_POS:  r = 4'd14;
      MSG_GPS_TIME: r = 4'd14;
      MSG_ALT:      r = 4'd5;
      MSG_REQ:      r = 4'd0;
      MSG_SCI:      r = 4'd3;
      default:      r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/dfrc_front.sv]
// serial parser: hunts for dle, reads the id, walks the body and queues operations
// depends on dfrc_pkg

module dfrc_front
  import dfrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rx_byte, cmd_id, cmd_length
  input  logic        s_tuser,   // req_type
  input  logic        q_full,
  output logic        push,
  output op_t         push_op
);

  phase_t     phase, phase_next;
  msg_t       msg, msg_next;
  logic [3:0] body_count, body_count_next;
  logic [7:0] frag_seq, frag_seq_next;
  logic [7:0] frag_data, frag_data_next;

  logic       accept;
  logic [7:0] rx_byte;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign rx_byte  = s_tdata[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      msg        <= MSG_GPS_POS;
      body_count <= 4'd0;
      frag_seq   <= 8'd0;
      frag_data  <= 8'd0;
    end else begin
      phase      <= phase_next;
      msg        <= msg_next;
      body_count <= body_count_next;
      frag_seq   <= frag_seq_next;
      frag_data  <= frag_data_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    msg_next        = msg;
    body_count_next = body_count;
    frag_seq_next   = frag_seq;
    frag_data_next  = frag_data;
    push            = 1'b0;
    push_op.code    = OP_TABLE;
    push_op.a       = s_tdata[15:8];
    push_op.b       = s_tdata[23:16];
    if (accept) begin
      if (s_tuser) begin
        push = 1'b1;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (rx_byte == DleByte) phase_next = PH_ID;
          end
          PH_ID: begin
            if (rx_byte >= IdGpsPos && rx_byte <= IdSciFrag) begin
              msg_next        = msg_t'(rx_byte[2:0]);
              body_count_next = 4'd0;
              phase_next      = PH_BODY;
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_BODY: begin
            if (msg == MSG_SCI) begin
              if (body_count == 4'd1) frag_seq_next = rx_byte;
              if (body_count == 4'd2) frag_data_next = rx_byte;
            end
            if (body_count != body_last(msg)) begin
              body_count_next = body_count + 4'd1;
            end else begin
              phase_next      = PH_HUNT;
              body_count_next = 4'd0;
              if (rx_byte != EtxByte) begin
                push         = 1'b1;
                push_op.code = OP_NO_ETX;
              end else if (msg == MSG_REQ) begin
                push         = 1'b1;
                push_op.code = OP_REQ;
              end else if (msg == MSG_SCI) begin
                push         = 1'b1;
                push_op.code = OP_FRAG;
                push_op.a    = frag_seq;
                push_op.b    = frag_data;
              end
            end
          end
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

endmodule

[hdl/dfrc_queue.sv]
// short operation queue between parser and command engine
// depends on dfrc_pkg

module dfrc_queue
  import dfrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       head,
  output q_status_t stat
);

  localparam int AW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);

  op_t            entries [QueueDepth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (fill == CW'(QueueDepth));
  assign stat.empty = (fill == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(QueueDepth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QueueDepth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) fill <= fill + CW'(1);
      else if (!do_push && do_pop) fill <= fill - CW'(1);
    end
  end

endmodule

[hdl/dfrc_back.sv]
// command engine: length table, command buffer, reassembly and result output register
// depends on dfrc_pkg

module dfrc_back
  import dfrc_pkg::*;
#(
  parameter int CMD_BUFFER_DEPTH = CmdBufferDepth
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  op_t                                  head,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,  // out_byte, byte_index, pad
  output logic [2:0]                           m_tuser,  // kind
  output logic                                 m_tlast,
  output logic [$clog2(CMD_BUFFER_DEPTH):0]    count
);

  localparam int AW = $clog2(CMD_BUFFER_DEPTH);
  localparam int CW = AW + 1;

  bk_state_t       state, state_next;
  logic [CW-1:0]   count_next;
  logic [AW-1:0]   idx, idx_next;
  logic [7:0]      first_byte, first_next;
  kind_t           emit_kind, emit_kind_next;

  logic [7:0]      tbl_len [TableDepth];
  logic [TableDepth-1:0] tbl_vld;
  logic [7:0]      tbl_rd_len;
  logic            tbl_rd_valid;
  logic            tbl_we;
  logic            tbl_re;
  logic [7:0]      tbl_raddr;

  logic [7:0]      cmd_buf [CMD_BUFFER_DEPTH];
  logic [7:0]      buf_rdata;
  logic            buf_we;

  logic            out_valid;
  kind_t           out_kind;
  logic [7:0]      out_byte;
  logic [4:0]      out_index;
  logic            out_last;

  logic            slot_free;
  logic            load;
  kind_t           ld_kind;
  logic [7:0]      ld_byte;
  logic [4:0]      ld_index;
  logic            ld_last;
  logic            emit_done;

  assign slot_free = !out_valid || m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {3'b000, out_index, out_byte};
  assign m_tuser   = out_kind;
  assign m_tlast   = out_last;
  assign emit_done = ((CW'(idx) + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      count      <= '0;
      idx        <= '0;
      first_byte <= 8'd0;
      emit_kind  <= KIND_KNOWN;
    end else begin
      state      <= state_next;
      count      <= count_next;
      idx        <= idx_next;
      first_byte <= first_next;
      emit_kind  <= emit_kind_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    first_next     = first_byte;
    emit_kind_next = emit_kind;
    pop            = 1'b0;
    tbl_we         = 1'b0;
    tbl_re         = 1'b0;
    tbl_raddr      = first_byte;
    buf_we         = 1'b0;
    load           = 1'b0;
    ld_kind        = KIND_REQ;
    ld_byte        = 8'd0;
    ld_index       = 5'd0;
    ld_last        = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && slot_free) begin
          pop = 1'b1;
          unique case (head.code)
            OP_TABLE: tbl_we = 1'b1;
            OP_REQ: begin
              load    = 1'b1;
              ld_kind = KIND_REQ;
            end
            OP_NO_ETX: begin
              load    = 1'b1;
              ld_kind = KIND_NO_ETX;
            end
            OP_FRAG: begin
              if (head.a == 8'(count)) begin
                buf_we = 1'b1;
                tbl_re = 1'b1;
                if (count == '0) begin
                  first_next = head.b;
                  tbl_raddr  = head.b;
                end
                count_next = count + CW'(1);
                state_next = BK_LOOKUP;
              end else begin
                count_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      BK_LOOKUP: begin
        if (tbl_rd_valid && tbl_rd_len == 8'(count)) begin
          emit_kind_next = KIND_KNOWN;
          idx_next       = '0;
          state_next     = BK_EMIT_RD;
        end else if (!tbl_rd_valid) begin
          emit_kind_next = KIND_UNKNOWN;
          idx_next       = '0;
          state_next     = BK_EMIT_RD;
        end else if (count >= CW'(CMD_BUFFER_DEPTH)) begin
          if (slot_free) begin
            load       = 1'b1;
            ld_kind    = KIND_OVERFLOW;
            count_next = '0;
            state_next = BK_IDLE;
          end
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_EMIT_RD: state_next = BK_EMIT_WR;
      BK_EMIT_WR: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_kind  = emit_kind;
          ld_byte  = buf_rdata;
          ld_index = 5'(idx);
          ld_last  = emit_done;
          if (emit_done) begin
            count_next = '0;
            state_next = BK_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = BK_EMIT_RD;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // length table: entry data in memory, known marks in flip-flops
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_len[head.a] <= head.b;
    if (tbl_re) begin
      tbl_rd_len   <= tbl_len[tbl_raddr];
      tbl_rd_valid <= tbl_vld[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= '0;
    end else if (tbl_we) begin
      tbl_vld[head.a] <= 1'b1;
    end
  end

  // command buffer
  always_ff @(posedge clk) begin
    if (buf_we) cmd_buf[count[AW-1:0]] <= head.b;
    buf_rdata <= cmd_buf[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= ld_kind;
      out_byte  <= ld_byte;
      out_index <= ld_index;
      out_last  <= ld_last;
    end
  end

endmodule

[hdl/dle_frame_receiver_cmd_reassembly_core.sv]
// top level of the dle frame receiver with science command reassembly
// depends on dfrc_pkg, dfrc_front, dfrc_queue, dfrc_back

// A serial byte or a length-table write is accepted whenever the four-entry
// operation queue has room; the parser itself never stalls beyond that. The
// command engine behind the queue handles a table write, a data request or a
// missing-ETX event from its idle state, a science fragment by a length-table
// read followed by a compare, and each byte of a finished or unknown command
// as it is sent out by a read then a load, since each byte is read from the
// command buffer memory before it is loaded into the output register. Results
// wait in that output register, so m_tready low holds up only the engine, and
// the parser keeps accepting until the queue fills. Events and command bytes
// leave with kind on m_tuser and tlast on the final result of each input.

module dle_frame_receiver_cmd_reassembly_core
  import dfrc_pkg::*;
#(
  parameter int CMD_BUFFER_DEPTH = CmdBufferDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rx_byte, cmd_id, cmd_length
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte, byte_index, zero pad
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast
);

  localparam int CW = $clog2(CMD_BUFFER_DEPTH) + 1;

  logic          push;
  op_t           push_op;
  op_t           head;
  logic          pop;
  q_status_t     q_stat;
  logic [CW-1:0] bk_count;

  dfrc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_stat.full),
    .push     (push),
    .push_op  (push_op)
  );

  dfrc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  dfrc_back #(
    .CMD_BUFFER_DEPTH (CMD_BUFFER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_stat.empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .count    (bk_count)
  );

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue flagged full and empty together");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bk_count <= CW'(CMD_BUFFER_DEPTH))
    else $error("assembled count beyond buffer depth");

  a_event_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_REQ || m_tuser == KIND_NO_ETX || m_tuser == KIND_OVERFLOW)
    |-> m_tlast && m_tdata == 16'd0)
    else $error("event result without last mark or with payload");
`endif

endmodule
